// ===== src/mbed_pkg.sv =====
// mbed_pkg: shared widths, fixed-point constants and the sequencer state type
// for the pointer motion smoother. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mbed_pkg;

	localparam int FRAC_BITS = 16;
	localparam int BL_W      = 30;
	localparam int RES_W     = 18;
	localparam int MOVE_W    = 16;
	localparam int DT_W      = 20;
	localparam int SF_W      = 20;
	localparam int STR_W     = 16;
	localparam int DTE_W     = 17;
	localparam int R_W       = FRAC_BITS + 1;

	localparam logic [BL_W-1:0]  MAX_BACKLOG = BL_W'(4000 * (1 << FRAC_BITS));
	localparam logic [BL_W-1:0]  SETTLED     = BL_W'(1 << (FRAC_BITS - 2));
	localparam logic [DTE_W-1:0] MAX_DT_US   = DTE_W'(100000);
	localparam logic [DTE_W-1:0] FIRST_DT_US = DTE_W'(16667);
	localparam logic [R_W-1:0]   ONE_F       = R_W'(1 << FRAC_BITS);
	localparam logic [30:0]      ONE_I       = 31'(1 << 30);
	localparam logic [32:0]      LN2_I       = 33'd744261118;
	localparam logic [3:0]       TAYLOR_N    = 4'd13;

	// shared divider
	localparam int DIV_W = 64;
	localparam int DSR_W = 33;
	localparam int CNT_W = 7;

	// shared multiplier
	localparam int MUL_A_W = 31;
	localparam int MUL_B_W = 30;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;

	typedef struct packed {
		logic             start;
		logic [CNT_W-1:0] steps;
	} div_req_t;

	typedef struct packed {
		logic done;
	} div_rsp_t;

	typedef enum logic [14:0] {
		S_IDLE = 15'b000000000000001,
		S_NUM  = 15'b000000000000010,
		S_DEN  = 15'b000000000000100,
		S_CMP  = 15'b000000000001000,
		S_DX   = 15'b000000000010000,
		S_DK   = 15'b000000000100000,
		S_TM   = 15'b000000001000000,
		S_TD   = 15'b000000010000000,
		S_TW   = 15'b000000100000000,
		S_REL  = 15'b000001000000000,
		S_MBX  = 15'b000010000000000,
		S_MBY  = 15'b000100000000000,
		S_MOX  = 15'b001000000000000,
		S_MOY  = 15'b010000000000000,
		S_QY   = 15'b100000000000000
	} state_t;

endpackage
`default_nettype wire

// ===== src/mbed_div.sv =====
// mbed_div: radix-2 restoring divider, one quotient bit per cycle.
// Depends on mbed_pkg. Dividend is left-aligned; quotient builds in the low bits.
`timescale 1ns / 1ps
`default_nettype none
module mbed_div (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire mbed_pkg::div_req_t        req,
	input  wire logic [mbed_pkg::DIV_W-1:0] dividend,
	input  wire logic [mbed_pkg::DSR_W-1:0] divisor,
	output mbed_pkg::div_rsp_t             rsp,
	output logic      [mbed_pkg::DIV_W-1:0] quotient
);
	import mbed_pkg::*;

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0] dvd_q;
	logic [DSR_W-1:0] dsr_q;
	logic [DSR_W-1:0] rem_q;
	logic [DSR_W:0]   trial;
	logic [DSR_W:0]   diff;
	logic             fits;

	assign trial = {rem_q, dvd_q[DIV_W-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
			dvd_q <= {dvd_q[DIV_W-2:0], fits};
		end
	end

	assign rsp.done  = done_q;
	assign quotient  = dvd_q;

endmodule
`default_nettype wire

// ===== src/motion_backlog_exponential_drain.sv =====
// motion_backlog_exponential_drain: top level, config registers, state, sequencer
// and shared multiplier. Depends on mbed_pkg and mbed_div.
//
// Two-axis pointer smoother. Motion beats add counts to per-axis Q13.16
// backlogs (saturated at +/-4000). A tick beat with the smoother enabled and
// the pointer grabbed releases the fraction 1-exp(-dt/tau) of both backlogs,
// scales it by the frame factor and rounds it with a carried residual. Every
// input beat yields exactly one output beat. Motion beats, clearing ticks and
// settled ticks finish in the idle state. A draining tick with nonzero
// strength forms dt*13107 and strength*100000, does the 61-step divide giving
// dt/tau, the split by ln2 (compare and subtract against ln2 shifted by
// 4..0), 13 Taylor terms (multiply, start, then a 30-step divide by the term
// index through one restoring divider that yields one quotient bit per cycle),
// forms the fraction and runs the final states S_MBX to S_QY; a zero strength
// or a very long dt/tau skips to those final states.
// Input stall is low only when the sequencer is idle and the output register
// is free or being taken. Config writes are expected only while idle.
`timescale 1ns / 1ps
`default_nettype none
module motion_backlog_exponential_drain (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// config
	input  wire logic                          cfg_we,
	input  wire logic                          cfg_index,
	input  wire logic [mbed_pkg::STR_W-1:0]    cfg_data,
	// input channel
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic                          kind,
	input  wire logic signed [15:0]            motion_x,
	input  wire logic signed [15:0]            motion_y,
	input  wire logic [mbed_pkg::DT_W-1:0]     elapsed_us,
	input  wire logic [mbed_pkg::SF_W-1:0]     scale_factor,
	input  wire logic                          pointer_grabbed,
	// output channel
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic signed [mbed_pkg::MOVE_W-1:0] move_x,
	output logic signed [mbed_pkg::MOVE_W-1:0] move_y,
	output logic                               move_valid,
	output logic                               draining
);
	import mbed_pkg::*;

	localparam logic CFG_ENABLE   = 1'b0;
	localparam logic CFG_STRENGTH = 1'b1;

	typedef struct packed {
		logic signed [MOVE_W-1:0] move;
		logic signed [RES_W-1:0]  res;
	} quant_t;

	// saturate a widened backlog sum to +/-4000
	function automatic logic signed [BL_W-1:0] sat_bl(input logic signed [32:0] v);
		logic signed [32:0] hi;
		hi = 33'(MAX_BACKLOG);
		if (v > hi)
			sat_bl = BL_W'(hi);
		else if (v < -hi)
			sat_bl = BL_W'(-hi);
		else
			sat_bl = v[BL_W-1:0];
	endfunction

	function automatic logic busy_bl(input logic signed [BL_W-1:0] a,
	                                 input logic signed [BL_W-1:0] b);
		logic signed [BL_W-1:0] s;
		s = SETTLED;
		busy_bl = (a >= s) || (a <= -s) || (b >= s) || (b <= -s);
	endfunction

	// (magnitude product + half) >> 16; the sign is applied by the caller
	function automatic logic [32:0] round16(input logic [PROD_W-1:0] p);
		logic [PROD_W-1:0] t;
		t = (p + PROD_W'(1 << 15)) >> 16;
		round16 = t[32:0];
	endfunction

	// add residual, round half away from zero, saturate to 16 bits
	function automatic quant_t quantize(input logic signed [33:0] sx,
	                                    input logic signed [RES_W-1:0] res);
		logic signed [34:0] c;
		logic        [34:0] mag;
		logic        [34:0] nmag;
		logic signed [34:0] n;
		logic signed [34:0] rnew;
		quant_t             q;
		c    = 35'(sx) + 35'(res);
		mag  = c[34] ? 35'(-c) : 35'(c);
		nmag = (mag + 35'(1 << 15)) >> 16;
		n    = c[34] ? -$signed(nmag) : $signed(nmag);
		rnew = c - (n <<< 16);
		q.res = rnew[RES_W-1:0];
		if (!c[34] && nmag > 35'd32767)
			q.move = 16'sd32767;
		else if (c[34] && nmag > 35'd32768)
			q.move = -16'sd32768;
		else
			q.move = n[MOVE_W-1:0];
		return q;
	endfunction

	state_t state_q;

	logic                     en_q;
	logic [STR_W-1:0]         str_q;
	logic signed [BL_W-1:0]   bx_q, by_q;
	logic signed [RES_W-1:0]  rx_q, ry_q;
	logic                     seen_q;
	logic [DTE_W-1:0]         dt_q;
	logic [SF_W-1:0]          fac_q;
	logic [30:0]              num_q;
	logic [4:0]               k_q;
	logic [29:0]              f_q;
	logic [34:0]              red_q;
	logic [30:0]              term_q;
	logic signed [32:0]       sum_q;
	logic [3:0]               n_q;
	logic [R_W-1:0]           r_q;
	logic signed [BL_W-1:0]   ox_q, oy_q;
	logic signed [MOVE_W-1:0] mx_q;
	logic [PROD_W-1:0]        prod_q;

	logic                     out_valid_q;
	logic signed [MOVE_W-1:0] move_x_q, move_y_q;
	logic                     move_valid_q, draining_q;

	// shared multiplier
	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic               mul_en;

	// divider
	div_req_t         div_req;
	div_rsp_t         div_rsp;
	logic [DIV_W-1:0] div_dvd;
	logic [DSR_W-1:0] div_dsr;
	logic [DIV_W-1:0] div_quo;

	mbed_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.dividend (div_dvd),
		.divisor  (div_dsr),
		.rsp      (div_rsp),
		.quotient (div_quo)
	);

	logic slot_free, accept, out_load;
	logic signed [BL_W-1:0] bx_abs_in, by_abs_in;
	logic signed [BL_W-1:0] bx_add, by_add;
	logic [37:0]            den20;
	logic [32:0]            o_mag;
	logic signed [BL_W-1:0] o_sgn;
	logic signed [33:0]     s_sgn;
	logic [30:0]            sum_c, e_sh, rel;
	logic [30:0]            r_full;
	quant_t                 qx, qy;
	logic [29:0]            tq;
	logic [34:0]            ln_sh;
	logic                   ln_fits;
	logic [34:0]            red_next;

	assign slot_free = !out_valid_q || !out_stall;
	assign in_stall  = !((state_q == S_IDLE) && slot_free);
	assign accept    = in_valid && !in_stall;
	// a result is loaded when an accepted beat does not start a drain, or when a drain finishes in S_QY with the slot free
	assign out_load  = (accept && !(kind && en_q && pointer_grabbed && busy_bl(bx_q, by_q)))
	                   || (state_q == S_QY && slot_free);

	assign bx_add = sat_bl(33'(bx_q) + {motion_x[15], motion_x, 16'b0});
	assign by_add = sat_bl(33'(by_q) + {motion_y[15], motion_y, 16'b0});
	assign bx_abs_in = bx_q[BL_W-1] ? -bx_q : bx_q;
	assign by_abs_in = by_q[BL_W-1] ? -by_q : by_q;

	assign den20 = ({5'b0, prod_q[32:0]} << 4) + ({5'b0, prod_q[32:0]} << 2);
	assign o_mag = round16(prod_q);
	assign tq    = div_quo[29:0];

	// x = k*ln2 + f, one quotient bit of k per cycle against shifted ln2
	assign ln_sh    = {2'b0, LN2_I} << n_q;
	assign ln_fits  = red_q >= ln_sh;
	assign red_next = ln_fits ? red_q - ln_sh : red_q;

	// release fraction from the Taylor sum
	assign sum_c  = sum_q[32] ? 31'd0 : (sum_q > 33'(ONE_I) ? ONE_I : sum_q[30:0]);
	assign e_sh   = sum_c >> k_q;
	assign rel    = ONE_I - e_sh;
	assign r_full = (rel + 31'(1 << 13)) >> 14;

	always_comb begin
		o_sgn = '0;
		s_sgn = '0;
		unique case (state_q)
			S_MBY:   o_sgn = bx_q[BL_W-1] ? -$signed(o_mag[BL_W-1:0]) : $signed(o_mag[BL_W-1:0]);
			S_MOX:   o_sgn = by_q[BL_W-1] ? -$signed(o_mag[BL_W-1:0]) : $signed(o_mag[BL_W-1:0]);
			S_MOY:   s_sgn = ox_q[BL_W-1] ? -$signed({1'b0, o_mag}) : $signed({1'b0, o_mag});
			S_QY:    s_sgn = oy_q[BL_W-1] ? -$signed({1'b0, o_mag}) : $signed({1'b0, o_mag});
			default: ;
		endcase
	end

	assign qx = quantize(s_sgn, rx_q);
	assign qy = quantize(s_sgn, ry_q);

	// operand select for the shared multiplier and the divider
	always_comb begin
		mul_a          = '0;
		mul_b          = '0;
		mul_en         = 1'b0;
		div_req.start  = 1'b0;
		div_req.steps  = '0;
		div_dvd        = '0;
		div_dsr        = '0;
		unique case (state_q)
			S_NUM: begin
				mul_a  = MUL_A_W'(dt_q);
				mul_b  = MUL_B_W'(13107);
				mul_en = 1'b1;
			end
			S_DEN: begin
				mul_a  = MUL_A_W'(str_q);
				mul_b  = MUL_B_W'(100000);
				mul_en = 1'b1;
			end
			S_CMP: begin
				div_req.start = {7'b0, num_q} < den20;
				div_req.steps = CNT_W'(61);
				div_dvd       = {num_q, 33'b0};
				div_dsr       = prod_q[32:0];
			end
			S_TM: begin
				mul_a  = term_q;
				mul_b  = f_q;
				mul_en = 1'b1;
			end
			S_TD: begin
				div_req.start = 1'b1;
				div_req.steps = CNT_W'(30);
				div_dvd       = {prod_q[59:30], 34'b0};
				div_dsr       = DSR_W'(n_q);
			end
			S_MBX: begin
				mul_a  = MUL_A_W'(unsigned'(bx_abs_in));
				mul_b  = MUL_B_W'(r_q);
				mul_en = 1'b1;
			end
			S_MBY: begin
				mul_a  = MUL_A_W'(unsigned'(by_abs_in));
				mul_b  = MUL_B_W'(r_q);
				mul_en = 1'b1;
			end
			S_MOX: begin
				mul_a  = MUL_A_W'(unsigned'(ox_q[BL_W-1] ? -ox_q : ox_q));
				mul_b  = MUL_B_W'(fac_q);
				mul_en = 1'b1;
			end
			S_MOY: begin
				mul_a  = MUL_A_W'(unsigned'(oy_q[BL_W-1] ? -oy_q : oy_q));
				mul_b  = MUL_B_W'(fac_q);
				mul_en = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mul_en)
			prod_q <= mul_a * mul_b;
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q  <= 1'b0;
			str_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ENABLE:   en_q  <= cfg_data[0];
				CFG_STRENGTH: str_q <= cfg_data;
				default:      ;
			endcase
		end
	end

	// sequencer and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			bx_q         <= '0;
			by_q         <= '0;
			rx_q         <= '0;
			ry_q         <= '0;
			seen_q       <= 1'b0;
			out_valid_q  <= 1'b0;
			move_x_q     <= '0;
			move_y_q     <= '0;
			move_valid_q <= 1'b0;
			draining_q   <= 1'b0;
			dt_q         <= '0;
			fac_q        <= '0;
			num_q        <= '0;
			k_q          <= '0;
			f_q          <= '0;
			red_q        <= '0;
			term_q       <= '0;
			sum_q        <= '0;
			n_q          <= '0;
			r_q          <= '0;
			ox_q         <= '0;
			oy_q         <= '0;
			mx_q         <= '0;
		end else begin
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						move_x_q     <= '0;
						move_y_q     <= '0;
						move_valid_q <= 1'b0;
						priority if (!kind) begin
							bx_q        <= bx_add;
							by_q        <= by_add;
							draining_q  <= busy_bl(bx_add, by_add);
						end else if (!en_q || !pointer_grabbed) begin
							bx_q        <= '0;
							by_q        <= '0;
							rx_q        <= '0;
							ry_q        <= '0;
							seen_q      <= 1'b0;
							draining_q  <= 1'b0;
						end else if (!busy_bl(bx_q, by_q)) begin
							bx_q        <= '0;
							by_q        <= '0;
							seen_q      <= 1'b0;
							draining_q  <= 1'b0;
						end else begin
							seen_q <= 1'b1;
							fac_q  <= scale_factor;
							if (!seen_q)
								dt_q <= FIRST_DT_US;
							else if (elapsed_us > DT_W'(MAX_DT_US))
								dt_q <= MAX_DT_US;
							else
								dt_q <= elapsed_us[DTE_W-1:0];
							if (str_q == '0) begin
								r_q     <= ONE_F;
								state_q <= S_MBX;
							end else begin
								state_q <= S_NUM;
							end
						end
					end
				end
				S_NUM: state_q <= S_DEN;
				S_DEN: begin
					num_q   <= prod_q[30:0];
					state_q <= S_CMP;
				end
				S_CMP: begin
					if ({7'b0, num_q} >= den20) begin
						r_q     <= ONE_F;
						state_q <= S_MBX;
					end else begin
						state_q <= S_DX;
					end
				end
				S_DX: begin
					if (div_rsp.done) begin
						red_q   <= div_quo[34:0];
						k_q     <= '0;
						n_q     <= 4'd4;
						state_q <= S_DK;
					end
				end
				S_DK: begin
					red_q <= red_next;
					k_q   <= {k_q[3:0], ln_fits};
					if (n_q == 4'd0) begin
						f_q     <= red_next[29:0];
						term_q  <= ONE_I;
						sum_q   <= 33'(ONE_I);
						n_q     <= 4'd1;
						state_q <= S_TM;
					end else begin
						n_q <= n_q - 4'd1;
					end
				end
				S_TM: state_q <= S_TD;
				S_TD: state_q <= S_TW;
				S_TW: begin
					if (div_rsp.done) begin
						term_q <= {1'b0, tq};
						// odd terms of exp(-f) subtract
						sum_q  <= n_q[0] ? sum_q - 33'(tq) : sum_q + 33'(tq);
						if (n_q == TAYLOR_N) begin
							state_q <= S_REL;
						end else begin
							n_q     <= n_q + 4'd1;
							state_q <= S_TM;
						end
					end
				end
				S_REL: begin
					r_q     <= r_full[R_W-1:0];
					state_q <= S_MBX;
				end
				S_MBX: state_q <= S_MBY;
				S_MBY: begin
					ox_q    <= o_sgn;
					bx_q    <= bx_q - o_sgn;
					state_q <= S_MOX;
				end
				S_MOX: begin
					oy_q    <= o_sgn;
					by_q    <= by_q - o_sgn;
					state_q <= S_MOY;
				end
				S_MOY: begin
					mx_q    <= qx.move;
					rx_q    <= qx.res;
					state_q <= S_QY;
				end
				S_QY: begin
					if (slot_free) begin
						ry_q         <= qy.res;
						move_x_q     <= mx_q;
						move_y_q     <= qy.move;
						move_valid_q <= (mx_q != '0) || (qy.move != '0);
						draining_q   <= busy_bl(bx_q, by_q);
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign move_x     = move_x_q;
	assign move_y     = move_y_q;
	assign move_valid = move_valid_q;
	assign draining   = draining_q;

`ifndef ASSERT_OFF
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> state_q == S_IDLE)
		else $error("input beat taken while sequencer busy");
	a_frac_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MBX |-> r_q <= ONE_F)
		else $error("release fraction above one");
	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == S_DX || state_q == S_TW))
		else $error("divider finished outside a waiting state");
	a_res_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(rx_q <= 18'sd32768) && (rx_q >= -18'sd32768)
		&& (ry_q <= 18'sd32768) && (ry_q >= -18'sd32768))
		else $error("residual outside half a count");
	a_done_next: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_QY && slot_free) |=> (out_valid && state_q == S_IDLE))
		else $error("drain result not presented");
`endif

endmodule
`default_nettype wire
